// File: rtl/vnorm_pkg.sv
`timescale 1ns / 1ps
// Shared widths, types and constants for the 3D vector normalizer.
// No dependencies; imported by every module of the block.
package vnorm_pkg;

	localparam int IN_W   = 32;                // component width, signed
	localparam int FRAC_W = 30;                // fraction bits of the unit vector
	localparam int OUT_W  = FRAC_W + 2;        // signed Q1.FRAC_W
	localparam int SQ_W   = 2 * IN_W;          // square and sum of squares
	localparam int S3_W   = SQ_W + 2;          // three times the sum
	localparam int Q_W    = FRAC_W + 1;        // quotient magnitude, up to 2^FRAC_W
	localparam int RES_W  = 2 * IN_W + 2 * FRAC_W + 6; // signed residual width
	localparam int QDEPTH = 4;
	localparam int QPTR_W = $clog2(QDEPTH);

	typedef logic [IN_W-1:0]         mag_t;
	typedef logic [SQ_W-1:0]         sq_t;
	typedef logic [S3_W-1:0]         s3_t;
	typedef logic signed [RES_W-1:0] res_t;
	typedef logic [Q_W-1:0]          quo_t;
	typedef logic signed [OUT_W-1:0] unit_t;

	localparam unit_t UNIT_POS_ONE = {2'b01, {FRAC_W{1'b0}}};
	localparam unit_t UNIT_NEG_ONE = {2'b11, {FRAC_W{1'b0}}};

	// one classified vector, handed from the front to the back
	typedef struct packed {
		sq_t [2:0]  sq;
		sq_t        sum;
		logic [2:0] neg;
		logic       zero;
	} qent_t;

endpackage

// File: rtl/vnorm_front.sv
`timescale 1ns / 1ps
// Front end: takes input beats, forms magnitudes, squares and the squared length.
// Depends on vnorm_pkg.
module vnorm_front import vnorm_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  logic signed [IN_W-1:0] comp_x,
	input  logic signed [IN_W-1:0] comp_y,
	input  logic signed [IN_W-1:0] comp_z,
	output logic                   push_valid,
	input  logic                   push_ready,
	output qent_t                  push_data
);

	logic v_s1, v_s2, v_s3;
	logic en;
	logic signed [2:0][IN_W-1:0] comp;
	mag_t [2:0] mag_d;
	mag_t [2:0] mag_s1;
	logic [2:0] neg_s1, neg_s2, neg_s3;
	logic zero_s1, zero_s2, zero_s3;
	sq_t [2:0] sq_s2, sq_s3;
	sq_t sum_s3;

	assign en       = !v_s3 || push_ready;
	assign in_ready = en;

	always_comb begin
		comp[0] = comp_x;
		comp[1] = comp_y;
		comp[2] = comp_z;
		for (int i = 0; i < 3; i++) begin
			mag_d[i] = comp[i][IN_W-1] ? mag_t'(-comp[i]) : mag_t'(comp[i]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			mag_s1  <= mag_d;
			neg_s1  <= {comp_z[IN_W-1], comp_y[IN_W-1], comp_x[IN_W-1]};
			zero_s1 <= (comp_x == '0) && (comp_y == '0) && (comp_z == '0);
			for (int i = 0; i < 3; i++) begin
				sq_s2[i] <= sq_t'(mag_s1[i]) * sq_t'(mag_s1[i]);
			end
			neg_s2  <= neg_s1;
			zero_s2 <= zero_s1;
			sq_s3   <= sq_s2;
			sum_s3  <= sq_s2[0] + sq_s2[1] + sq_s2[2];
			neg_s3  <= neg_s2;
			zero_s3 <= zero_s2;
		end
	end

	assign push_valid     = v_s3;
	assign push_data.sq   = sq_s3;
	assign push_data.sum  = sum_s3;
	assign push_data.neg  = neg_s3;
	assign push_data.zero = zero_s3;

endmodule

// File: rtl/vnorm_queue.sv
`timescale 1ns / 1ps
// Short FIFO between front and back so each side can stall on its own.
// Depends on vnorm_pkg.
module vnorm_queue import vnorm_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push_valid,
	output logic  push_ready,
	input  qent_t push_data,
	output logic  pop_valid,
	input  logic  pop_ready,
	output qent_t pop_data
);

	qent_t mem_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [QPTR_W:0]   cnt_q;
	logic push, pop;

	assign push_ready = cnt_q != (QPTR_W+1)'(QDEPTH);
	assign pop_valid  = cnt_q != '0;
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;
	assign pop_data   = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop)  rd_ptr_q <= rd_ptr_q + 1'b1;
			if (push && !pop)      cnt_q <= cnt_q + 1'b1;
			else if (pop && !push) cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_ptr_q] <= push_data;
	end

endmodule

// File: rtl/vnorm_back.sv
`timescale 1ns / 1ps
// Back end: one pipeline stage per quotient bit, shift-add residual recurrence,
// then sign and zero handling into the output register. Depends on vnorm_pkg.
module vnorm_back import vnorm_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  pop_valid,
	output logic  pop_ready,
	input  qent_t pop_data,
	output logic  out_valid,
	input  logic  out_ready,
	output unit_t unit_x,
	output unit_t unit_y,
	output unit_t unit_z,
	output logic  zero_length
);

	// Quotient bit b is kept when (2q-1)^2*S <= 4*m^2*2^(2F). The residual
	// e = 4m^2 2^(2F) - c^2 S and u = c*S + 2^b S advance by shifts and adds only.
	logic en;
	logic       vld_s  [0:Q_W];
	logic [2:0] neg_s  [0:Q_W];
	logic       zero_s [0:Q_W];
	quo_t [2:0] q_s    [0:Q_W];
	res_t [2:0] e_s    [0:FRAC_W];
	res_t [2:0] u_s    [0:FRAC_W];
	sq_t        s_s    [0:FRAC_W-1];
	s3_t        s3_s   [0:FRAC_W-1];

	logic       vld_o_q;
	unit_t [2:0] unit_o_q;
	logic       zero_o_q;

	assign en        = !vld_o_q || out_ready;
	assign pop_ready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k <= Q_W; k++) vld_s[k] <= 1'b0;
			vld_o_q <= 1'b0;
		end else if (en) begin
			vld_s[0] <= pop_valid;
			for (int k = 0; k < Q_W; k++) vld_s[k+1] <= vld_s[k];
			vld_o_q <= vld_s[Q_W];
		end
	end

	// seed the recurrence with c = -1
	always_ff @(posedge clk) begin
		if (en) begin
			s_s[0]    <= pop_data.sum;
			s3_s[0]   <= s3_t'(pop_data.sum) + s3_t'({pop_data.sum, 1'b0});
			neg_s[0]  <= pop_data.neg;
			zero_s[0] <= pop_data.zero;
			for (int i = 0; i < 3; i++) begin
				e_s[0][i] <= (res_t'(pop_data.sq[i]) <<< (2 * FRAC_W + 2))
					- res_t'(pop_data.sum);
				u_s[0][i] <= (res_t'(pop_data.sum) <<< FRAC_W) - res_t'(pop_data.sum);
				q_s[0][i] <= '0;
			end
		end
	end

	for (genvar k = 0; k <= FRAC_W; k++) begin : g_step
		localparam int B = FRAC_W - k;
		res_t [2:0] trial;
		logic [2:0] take;

		always_comb begin
			for (int i = 0; i < 3; i++) begin
				trial[i] = e_s[k][i] - (u_s[k][i] <<< (B + 2));
				take[i]  = !trial[i][RES_W-1];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				for (int i = 0; i < 3; i++) begin
					q_s[k+1][i] <= q_s[k][i] | (quo_t'(take[i]) << B);
				end
				neg_s[k+1]  <= neg_s[k];
				zero_s[k+1] <= zero_s[k];
			end
		end

		if (B > 0) begin : g_res
			always_ff @(posedge clk) begin
				if (en) begin
					for (int i = 0; i < 3; i++) begin
						e_s[k+1][i] <= take[i] ? trial[i] : e_s[k][i];
						u_s[k+1][i] <= take[i]
							? u_s[k][i] + (res_t'(s3_s[k]) <<< (B - 1))
							: u_s[k][i] - (res_t'(s_s[k]) <<< (B - 1));
					end
				end
			end
		end

		if (B > 1) begin : g_sum
			always_ff @(posedge clk) begin
				if (en) begin
					s_s[k+1]  <= s_s[k];
					s3_s[k+1] <= s3_s[k];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			zero_o_q <= zero_s[Q_W];
			for (int i = 0; i < 3; i++) begin
				if (zero_s[Q_W])         unit_o_q[i] <= '0;
				else if (neg_s[Q_W][i])  unit_o_q[i] <= -unit_t'(q_s[Q_W][i]);
				else                     unit_o_q[i] <= unit_t'(q_s[Q_W][i]);
			end
		end
	end

	assign out_valid   = vld_o_q;
	assign unit_x      = unit_o_q[0];
	assign unit_y      = unit_o_q[1];
	assign unit_z      = unit_o_q[2];
	assign zero_length = zero_o_q;

endmodule

// File: rtl/vector_normalize_3d.sv
`timescale 1ns / 1ps
// 3D vector normalizer, signed Q16.16 in, signed Q1.30 out with round to nearest.
// Pipeline from input beat to output beat: three front stages, the queue,
// one seed stage, 31 quotient-bit stages, output register.
// One vector per cycle unless stalled; the 4-entry queue absorbs output stalls.
// Reset (arst_n low, asynchronous) clears all valid flags and queue pointers.
// Depends on vnorm_pkg, vnorm_front, vnorm_queue, vnorm_back.
module vector_normalize_3d import vnorm_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  logic signed [IN_W-1:0] comp_x,
	input  logic signed [IN_W-1:0] comp_y,
	input  logic signed [IN_W-1:0] comp_z,
	output logic                   out_valid,
	input  logic                   out_ready,
	output unit_t                  unit_x,
	output unit_t                  unit_y,
	output unit_t                  unit_z,
	output logic                   zero_length
);

	logic  push_valid, push_ready, pop_valid, pop_ready;
	qent_t push_data, pop_data;

	vnorm_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.comp_x     (comp_x),
		.comp_y     (comp_y),
		.comp_z     (comp_z),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data)
	);

	vnorm_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_data   (pop_data)
	);

	vnorm_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.pop_valid   (pop_valid),
		.pop_ready   (pop_ready),
		.pop_data    (pop_data),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.unit_x      (unit_x),
		.unit_y      (unit_y),
		.unit_z      (unit_z),
		.zero_length (zero_length)
	);

endmodule

// File: rtl/vnorm_checker.sv
`timescale 1ns / 1ps
// Port-level checks for the normalizer, bound onto the top level.
// Depends on vnorm_pkg and vector_normalize_3d.
module vnorm_checker import vnorm_pkg::*; (
	input logic                   clk,
	input logic                   arst_n,
	input logic                   in_valid,
	input logic                   in_ready,
	input logic signed [IN_W-1:0] comp_x,
	input logic signed [IN_W-1:0] comp_y,
	input logic signed [IN_W-1:0] comp_z,
	input logic                   out_valid,
	input logic                   out_ready,
	input unit_t                  unit_x,
	input unit_t                  unit_y,
	input unit_t                  unit_z,
	input logic                   zero_length
);

	// hold a stalled input beat
	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_ready |=> in_valid && $stable(comp_x) && $stable(comp_y)
			&& $stable(comp_z))
		else $error("stalled input beat changed");

	// hold a stalled output beat
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(unit_x) && $stable(unit_y)
			&& $stable(unit_z) && $stable(zero_length))
		else $error("stalled output beat changed");

	a_zero_vec: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && zero_length |-> unit_x == '0 && unit_y == '0 && unit_z == '0)
		else $error("zero-length beat with nonzero components");

	a_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !zero_length |-> unit_x != '0 || unit_y != '0 || unit_z != '0)
		else $error("nonzero vector normalized to zero");

	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> unit_x <= UNIT_POS_ONE && unit_x >= UNIT_NEG_ONE
			&& unit_y <= UNIT_POS_ONE && unit_y >= UNIT_NEG_ONE
			&& unit_z <= UNIT_POS_ONE && unit_z >= UNIT_NEG_ONE)
		else $error("unit component outside [-1, 1]");

endmodule

bind vector_normalize_3d vnorm_checker u_chk (.*);
